// ----- sv/lst_pkg.sv -----
// Shared types, token kind codes and character constants for the tokenizer.
`default_nettype none

package lst_pkg;

    // Longest identifier or number run before it is split.
    localparam int LST_MAX_LEXEME = 64;
    // Most tokens that one input word can produce.
    localparam int LST_MAXRES     = 3;
    // Entries in the queue between the scanner and the output stage.
    localparam int LST_QDEPTH     = 4;

    localparam int KIND_W  = 6;
    localparam int POS_W   = 32;
    localparam int LEN_W   = 7;
    localparam int CNT_W   = 2;
    localparam int CFGIX_W = 2;

    // Configuration register indexes.
    localparam logic [CFGIX_W-1:0] CFG_SKIP_WS     = 2'd0;
    localparam logic [CFGIX_W-1:0] CFG_SINGLE_CHAR = 2'd1;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT     = 6'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER    = 6'd2;
    localparam logic [KIND_W-1:0] KIND_SQUOTE    = 6'd3;
    localparam logic [KIND_W-1:0] KIND_DQUOTE    = 6'd4;
    localparam logic [KIND_W-1:0] KIND_BSLASH    = 6'd5;
    localparam logic [KIND_W-1:0] KIND_SPACE     = 6'd6;
    localparam logic [KIND_W-1:0] KIND_TAB       = 6'd7;
    localparam logic [KIND_W-1:0] KIND_HASH      = 6'd8;
    localparam logic [KIND_W-1:0] KIND_USCORE    = 6'd9;
    localparam logic [KIND_W-1:0] KIND_LBRACKET  = 6'd10;
    localparam logic [KIND_W-1:0] KIND_LBRACE    = 6'd11;
    localparam logic [KIND_W-1:0] KIND_LPAREN    = 6'd12;
    localparam logic [KIND_W-1:0] KIND_RBRACKET  = 6'd13;
    localparam logic [KIND_W-1:0] KIND_RBRACE    = 6'd14;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 6'd15;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 6'd16;
    localparam logic [KIND_W-1:0] KIND_STAR      = 6'd17;
    localparam logic [KIND_W-1:0] KIND_PLUS      = 6'd18;
    localparam logic [KIND_W-1:0] KIND_MINUS     = 6'd19;
    localparam logic [KIND_W-1:0] KIND_SEMI      = 6'd20;
    localparam logic [KIND_W-1:0] KIND_AMP       = 6'd21;
    localparam logic [KIND_W-1:0] KIND_SLASH     = 6'd22;
    localparam logic [KIND_W-1:0] KIND_PIPE      = 6'd23;
    localparam logic [KIND_W-1:0] KIND_QMARK     = 6'd24;
    localparam logic [KIND_W-1:0] KIND_NUL       = 6'd25;
    localparam logic [KIND_W-1:0] KIND_EQUALS    = 6'd26;
    localparam logic [KIND_W-1:0] KIND_EQUIV     = 6'd27;
    localparam logic [KIND_W-1:0] KIND_PERCENT   = 6'd28;
    localparam logic [KIND_W-1:0] KIND_SECTION   = 6'd29;
    localparam logic [KIND_W-1:0] KIND_OPENSEC   = 6'd30;
    localparam logic [KIND_W-1:0] KIND_CLOSESEC  = 6'd31;
    localparam logic [KIND_W-1:0] KIND_LESS      = 6'd32;
    localparam logic [KIND_W-1:0] KIND_LTE       = 6'd33;
    localparam logic [KIND_W-1:0] KIND_GREAT     = 6'd34;
    localparam logic [KIND_W-1:0] KIND_GTE       = 6'd35;
    localparam logic [KIND_W-1:0] KIND_NOT       = 6'd36;
    localparam logic [KIND_W-1:0] KIND_NOTEQ     = 6'd37;
    localparam logic [KIND_W-1:0] KIND_DOT       = 6'd38;
    localparam logic [KIND_W-1:0] KIND_ELLIPSIS  = 6'd39;
    localparam logic [KIND_W-1:0] KIND_END       = 6'd40;

    // Characters with a role in the scanner.
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
    } token_t;

    // All tokens decided by one input word, oldest in slot 0.
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        token_t [LST_MAXRES-1:0]         tok;
    } bundle_t;

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h27:   k = KIND_SQUOTE;
            8'h22:   k = KIND_DQUOTE;
            8'h5C:   k = KIND_BSLASH;
            8'h20:   k = KIND_SPACE;
            8'h09:   k = KIND_TAB;
            8'h23:   k = KIND_HASH;
            8'h5F:   k = KIND_USCORE;
            8'h5B:   k = KIND_LBRACKET;
            8'h7B:   k = KIND_LBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h5D:   k = KIND_RBRACKET;
            8'h7D:   k = KIND_RBRACE;
            8'h29:   k = KIND_RPAREN;
            8'h2C:   k = KIND_COMMA;
            8'h2A:   k = KIND_STAR;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h3B:   k = KIND_SEMI;
            8'h26:   k = KIND_AMP;
            8'h2F:   k = KIND_SLASH;
            8'h7C:   k = KIND_PIPE;
            8'h3F:   k = KIND_QMARK;
            8'h00:   k = KIND_NUL;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lst_front.sv -----
// Scanner front end: keeps the pending token and turns each input word into a token bundle.
`default_nettype none

module lst_front #(
    parameter int MAX_LEXEME = lst_pkg::LST_MAX_LEXEME
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [lst_pkg::CFGIX_W-1:0]  cfg_index,
    input  wire logic                         cfg_data,
    input  wire logic                         in_fire,
    input  wire logic [7:0]                   ch,
    input  wire logic                         end_of_input,
    output logic                              q_push,
    output lst_pkg::bundle_t                  q_data
);
    import lst_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_EQ,
        MODE_PCT,
        MODE_LT,
        MODE_GT,
        MODE_BANG,
        MODE_DOT,
        MODE_DOTDOT
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             skip_ws_reg;
    logic             single_reg;

    logic             is_letter, is_digit, is_ws;
    bundle_t          bnd;
    logic             used;

    function automatic bundle_t add_tok(input bundle_t b, input logic [KIND_W-1:0] k,
                                        input logic [POS_W-1:0] s, input logic [LEN_W-1:0] l);
        bundle_t r;
        r = b;
        if (r.cnt != CNT_W'(LST_MAXRES)) begin
            r.tok[r.cnt].kind  = k;
            r.tok[r.cnt].start = s;
            r.tok[r.cnt].len   = l;
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    assign is_digit  = (ch >= 8'h30 && ch <= 8'h39);
    assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);

    always_comb
    begin
        bnd        = '0;
        used       = 1'b0;
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;

        if (!end_of_input)
        begin
            // Try to extend the pending token with the new character.
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    if (!single_reg && (mode_reg == MODE_IDENT ? is_letter : is_digit)
                        && len_reg < LEN_W'(MAX_LEXEME))
                    begin
                        used     = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                MODE_EQ:
                begin
                    if (ch == CH_EQ)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_EQUIV, start_reg, 7'd2);
                    end
                end
                MODE_PCT:
                begin
                    if (ch == CH_PCT)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_SECTION, start_reg, 7'd2);
                    end
                    else if (ch == CH_LBRACE)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_OPENSEC, start_reg, 7'd2);
                    end
                    else if (ch == CH_RBRACE)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_CLOSESEC, start_reg, 7'd2);
                    end
                end
                MODE_LT:
                begin
                    if (ch == CH_EQ)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_LTE, start_reg, 7'd2);
                    end
                end
                MODE_GT:
                begin
                    if (ch == CH_EQ)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_GTE, start_reg, 7'd2);
                    end
                end
                MODE_BANG:
                begin
                    if (ch == CH_EQ)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_NOTEQ, start_reg, 7'd2);
                    end
                end
                MODE_DOT:
                begin
                    if (ch == CH_DOT)
                    begin
                        used      = 1'b1;
                        mode_next = MODE_DOTDOT;
                        len_next  = 7'd2;
                    end
                end
                MODE_DOTDOT:
                begin
                    if (ch == CH_DOT)
                    begin
                        used = 1'b1;
                        bnd  = add_tok(bnd, KIND_ELLIPSIS, start_reg, 7'd3);
                    end
                end
                default:
                begin
                    used = 1'b0;
                end
            endcase
            pos_next = pos_reg + 1'b1;
        end

        if (used)
        begin
            if (bnd.cnt != '0)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else
        begin
            // The pending token cannot grow: emit it.
            case (mode_reg)
                MODE_IDENT:  bnd = add_tok(bnd, KIND_IDENT, start_reg, len_reg);
                MODE_NUMBER: bnd = add_tok(bnd, KIND_NUMBER, start_reg, len_reg);
                MODE_EQ:     bnd = add_tok(bnd, KIND_EQUALS, start_reg, 7'd1);
                MODE_PCT:    bnd = add_tok(bnd, KIND_PERCENT, start_reg, 7'd1);
                MODE_LT:     bnd = add_tok(bnd, KIND_LESS, start_reg, 7'd1);
                MODE_GT:     bnd = add_tok(bnd, KIND_GREAT, start_reg, 7'd1);
                MODE_BANG:   bnd = add_tok(bnd, KIND_NOT, start_reg, 7'd1);
                MODE_DOT:    bnd = add_tok(bnd, KIND_DOT, start_reg, 7'd1);
                MODE_DOTDOT:
                begin
                    bnd = add_tok(bnd, KIND_DOT, start_reg, 7'd1);
                    bnd = add_tok(bnd, KIND_DOT, start_reg + 1'b1, 7'd1);
                end
                default:
                begin
                    bnd = bnd;
                end
            endcase
            mode_next = MODE_IDLE;

            if (end_of_input)
            begin
                bnd = add_tok(bnd, KIND_END, pos_reg, 7'd0);
            end
            else if (!(skip_ws_reg && is_ws))
            begin
                // Scan the new character from a token boundary.
                if (is_letter || is_digit)
                begin
                    if (single_reg)
                    begin
                        bnd = add_tok(bnd, is_letter ? KIND_IDENT : KIND_NUMBER, pos_reg, 7'd1);
                    end
                    else
                    begin
                        mode_next  = is_letter ? MODE_IDENT : MODE_NUMBER;
                        start_next = pos_reg;
                        len_next   = 7'd1;
                    end
                end
                else
                begin
                    case (ch)
                        CH_EQ, CH_PCT, CH_LT, CH_GT, CH_BANG:
                        begin
                            mode_next  = (ch == CH_EQ)  ? MODE_EQ  :
                                         (ch == CH_PCT) ? MODE_PCT :
                                         (ch == CH_LT)  ? MODE_LT  :
                                         (ch == CH_GT)  ? MODE_GT  : MODE_BANG;
                            start_next = pos_reg;
                            len_next   = 7'd1;
                        end
                        CH_DOT:
                        begin
                            if (single_reg)
                            begin
                                bnd = add_tok(bnd, KIND_DOT, pos_reg, 7'd1);
                            end
                            else
                            begin
                                mode_next  = MODE_DOT;
                                start_next = pos_reg;
                                len_next   = 7'd1;
                            end
                        end
                        default:
                        begin
                            bnd = add_tok(bnd, single_kind(ch), pos_reg, 7'd1);
                        end
                    endcase
                end
            end
        end
    end

    assign q_push = in_fire && (bnd.cnt != '0);
    assign q_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            start_reg   <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
            skip_ws_reg <= 1'b1;
            single_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
            end
            if (cfg_we && cfg_index == CFG_SKIP_WS)
            begin
                skip_ws_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SINGLE_CHAR)
            begin
                single_reg <= cfg_data;
            end
        end
    end

    // The end marker always closes the stream and leaves the scanner idle.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_input |=> mode_reg == MODE_IDLE)
        else $error("scanner not idle after end marker");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_input |-> q_push)
        else $error("end marker produced no token");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER)
        |-> (len_reg != '0 && len_reg <= LEN_W'(MAX_LEXEME)))
        else $error("pending run length out of range");

endmodule

`default_nettype wire

// ----- sv/lst_queue.sv -----
// Small queue of token bundles between the scanner and the output stage.
`default_nettype none

module lst_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire lst_pkg::bundle_t  wr_data,
    input  wire logic              rd_en,
    output lst_pkg::bundle_t       rd_data,
    output logic                   full,
    output logic                   not_empty
);
    import lst_pkg::*;

    localparam int PTR_W = $clog2(LST_QDEPTH);
    localparam int CNT_QW = $clog2(LST_QDEPTH + 1);

    bundle_t            mem [LST_QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    assign full      = count_reg == CNT_QW'(LST_QDEPTH);
    assign not_empty = count_reg != '0;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(LST_QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(LST_QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/lst_back.sv -----
// Output stage: holds one bundle and hands its tokens out one word at a time.
`default_nettype none

module lst_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_not_empty,
    input  wire lst_pkg::bundle_t           q_data,
    output logic                            q_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [lst_pkg::KIND_W-1:0]      kind,
    output logic [lst_pkg::POS_W-1:0]       start_pos,
    output logic [lst_pkg::LEN_W-1:0]       length,
    output logic                            is_last
);
    import lst_pkg::*;

    bundle_t          bundle_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;
    logic             pop_fire;

    assign pop_fire  = pop && valid_reg;
    assign is_last   = idx_reg == (bundle_reg.cnt - 1'b1);
    // A new bundle loads when the stage is empty or its last token leaves.
    assign q_pop     = q_not_empty && (!valid_reg || (pop_fire && is_last));
    assign empty     = !valid_reg;
    assign kind      = bundle_reg.tok[idx_reg].kind;
    assign start_pos = bundle_reg.tok[idx_reg].start;
    assign length    = bundle_reg.tok[idx_reg].len;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bundle_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (pop_fire)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (bundle_reg.cnt != '0 && idx_reg < bundle_reg.cnt))
        else $error("token index outside the held bundle");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !is_last |=> !empty)
        else $error("bundle ended before its last token");

    a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg && q_not_empty |=> valid_reg)
        else $error("waiting bundle not loaded");

endmodule

`default_nettype wire

// ----- sv/lex_spec_tokenizer_unit.sv -----
// Top level of the streaming tokenizer: scanner, bundle queue and output stage.
`default_nettype none

// Streaming tokenizer. One character byte (or an end-of-input marker) is
// pushed per cycle; the scanner decides every token that the word completes
// in the same cycle and places up to three of them as one bundle into a
// four-entry queue. The output stage hands the tokens out oldest first, one
// word per cycle while pop is high, with is_last marking the final token
// caused by an input word. Input is taken every cycle while full is low, so
// a character stream runs at one byte per cycle as long as the consumer keeps
// up; the output port delivers at most one token per cycle, which sets the
// sustained rate when bursts of short tokens appear (for example ".." followed
// by "+" yields three tokens). A token passes through a queue entry and then
// the output bundle register after the completing character is pushed.
// Registers (cfg_index): 0 skip_whitespace (reset 1), 1 single_char_mode
// (reset 0); writes to other indexes are ignored, and the port is always
// ready. Identifier and number runs longer than MAX_LEXEME are split.
module lex_spec_tokenizer_unit #(
    parameter int MAX_LEXEME = lst_pkg::LST_MAX_LEXEME
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lst_pkg::CFGIX_W-1:0] cfg_index,
    input  wire logic                        cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  ch,
    input  wire logic                        end_of_input,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [lst_pkg::KIND_W-1:0]       kind,
    output logic [lst_pkg::POS_W-1:0]        start_pos,
    output logic [lst_pkg::LEN_W-1:0]        length,
    output logic                             is_last
);
    import lst_pkg::*;

    logic    in_fire;
    logic    q_push, q_pop, q_full, q_not_empty;
    bundle_t q_wr_data, q_rd_data;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    // A word is taken only when the queue can hold whatever it produces.
    assign in_fire   = push && !q_full;

    lst_front #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .ch           (ch),
        .end_of_input (end_of_input),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    lst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_data   (q_wr_data),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    lst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .start_pos   (start_pos),
        .length      (length),
        .is_last     (is_last)
    );

endmodule

`default_nettype wire
